/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* sv/qrm_pkg.sv */
// ----------------------------------------------------------------------------
// qrm_pkg
// Types and constants of the quaternion to rotation matrix pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

  localparam int unsigned FRAC_BITS_DEF = 14;
  localparam int unsigned DATA_W        = 16;
  localparam int unsigned NUM_ELEM      = 9;
  localparam int unsigned REG_ADDR_W    = 3;

  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN = -32768;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_SCALAR_SUPPLIED = 1'b0;

  // per-request sideband that rides along the pipeline
  typedef struct packed {
    logic                     sel;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic signed [DATA_W-1:0] w;
  } qrm_side_t;

endpackage

/* sv/quaternion_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Unit quaternion to 3x3 rotation matrix in signed fixed point, saturated.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Handshake
//  request   qx_i qy_i qz_i qw_i                     start && !busy
//  result    m00_o .. m22_o                          done_o, one cycle
//  config    psel penable pwrite paddr pwdata prdata APB, pready tied high
//
//  One request per clock; busy stays low since nothing in the pipe stalls.
//  The square root resolves one root bit per stage, so the pipeline
//  grows with FRAC_BITS.
//  Every request takes the same path, also when qw is supplied, so results keep request order.
//  Reset clears all valid bits and sets scalar_supplied to 1.
//  The result side has no back-pressure; each result shows for one cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_to_rotation_matrix import qrm_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] qx_i,
  input  logic signed [DATA_W-1:0] qy_i,
  input  logic signed [DATA_W-1:0] qz_i,
  input  logic signed [DATA_W-1:0] qw_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] m00_o,
  output logic signed [DATA_W-1:0] m01_o,
  output logic signed [DATA_W-1:0] m02_o,
  output logic signed [DATA_W-1:0] m10_o,
  output logic signed [DATA_W-1:0] m11_o,
  output logic signed [DATA_W-1:0] m12_o,
  output logic signed [DATA_W-1:0] m20_o,
  output logic signed [DATA_W-1:0] m21_o,
  output logic signed [DATA_W-1:0] m22_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [REG_ADDR_W-1:0]    paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int unsigned N   = FRAC_BITS + 1;
  localparam int unsigned RB  = 2 * N;
  localparam int unsigned WW  = (FRAC_BITS + 2 > DATA_W) ? FRAC_BITS + 2 : DATA_W;
  localparam int unsigned PW  = DATA_W + WW;
  localparam int unsigned SW  = 2 * DATA_W;
  localparam int unsigned EW0 = (2 * FRAC_BITS > PW) ? 2 * FRAC_BITS : PW;
  localparam int unsigned EW  = EW0 + 3;
  localparam int unsigned LAT = 3 + (N + 1) + 4;

  localparam logic signed [EW-1:0] ONE2   = EW'(1) << (2 * FRAC_BITS);
  localparam logic signed [EW-1:0] HALF   = EW'(1) << (FRAC_BITS - 1);
  localparam logic signed [EW-1:0] SAT_HI = EW'(OUT_MAX);
  localparam logic signed [EW-1:0] SAT_LO = EW'(OUT_MIN);
  localparam logic signed [WW-1:0] W_ONE  = WW'(1) << FRAC_BITS;
  localparam int DIAG_MAX = ((1 << FRAC_BITS) > OUT_MAX) ? OUT_MAX : (1 << FRAC_BITS);
  localparam logic signed [DATA_W-1:0] DIAG_HI = DATA_W'(DIAG_MAX);

  // ---------------------------------------------------------------- config
  logic scalar_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scalar_q <= 1'b1;
    end else if (cfg_wr && (paddr[2] == REG_SCALAR_SUPPLIED)) begin
      scalar_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_SCALAR_SUPPLIED) ? {31'b0, scalar_q} : 32'b0;

  // ---------------------------------------------------------------- intake
  logic in_acc;

  assign busy   = 1'b0;
  assign in_acc = start && !busy;

  logic      s1_vld_q;
  qrm_side_t s1_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_side_q <= '{sel: scalar_q, x: qx_i, y: qy_i, z: qz_i, w: qw_i};
  end

  // ---------------------------------------------------------------- squares
  logic                 s2_vld_q;
  qrm_side_t            s2_side_q;
  logic signed [SW-1:0] s2_xx_q, s2_yy_q, s2_zz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_side_q <= s1_side_q;
    s2_xx_q   <= s1_side_q.x * s1_side_q.x;
    s2_yy_q   <= s1_side_q.y * s1_side_q.y;
    s2_zz_q   <= s1_side_q.z * s1_side_q.z;
  end

  // ---------------------------------------------------------------- radicand
  logic signed [EW-1:0] r_d;
  logic [RB-1:0]        rad_d;
  logic                 s3_vld_q;
  qrm_side_t            s3_side_q;
  logic [RB-1:0]        s3_rad_q;

  assign r_d   = ONE2 - EW'(s2_xx_q) - EW'(s2_yy_q) - EW'(s2_zz_q);
  // non-positive radicand gives w = 0
  assign rad_d = (!r_d[EW-1] && (r_d != '0)) ? r_d[RB-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_side_q <= s2_side_q;
    s3_rad_q  <= rad_d;
  end

  // ---------------------------------------------------------------- sqrt
  logic          sq_vld;
  qrm_side_t     sq_side;
  logic [N-1:0]  sq_root;

  qrm_isqrt #(
    .FRAC_BITS (FRAC_BITS)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_vld_q),
    .side_i  (s3_side_q),
    .rad_i   (s3_rad_q),
    .valid_o (sq_vld),
    .side_o  (sq_side),
    .root_o  (sq_root)
  );

  // ---------------------------------------------------------------- scalar pick
  logic signed [WW-1:0] w_d;
  logic                 s4_vld_q;
  qrm_side_t            s4_side_q;
  logic signed [WW-1:0] s4_w_q;

  assign w_d = sq_side.sel ? WW'(sq_side.w) : WW'($signed({1'b0, sq_root}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_side_q <= sq_side;
    s4_w_q    <= w_d;
  end

  // ---------------------------------------------------------------- products
  logic                 s5_vld_q;
  logic signed [SW-1:0] s5_xx_q, s5_yy_q, s5_zz_q, s5_xy_q, s5_xz_q, s5_yz_q;
  logic signed [PW-1:0] s5_xw_q, s5_yw_q, s5_zw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_xx_q <= s4_side_q.x * s4_side_q.x;
    s5_yy_q <= s4_side_q.y * s4_side_q.y;
    s5_zz_q <= s4_side_q.z * s4_side_q.z;
    s5_xy_q <= s4_side_q.x * s4_side_q.y;
    s5_xz_q <= s4_side_q.x * s4_side_q.z;
    s5_yz_q <= s4_side_q.y * s4_side_q.z;
    s5_xw_q <= PW'(s4_side_q.x) * PW'(s4_w_q);
    s5_yw_q <= PW'(s4_side_q.y) * PW'(s4_w_q);
    s5_zw_q <= PW'(s4_side_q.z) * PW'(s4_w_q);
  end

  // ---------------------------------------------------------------- sums
  logic signed [EW-1:0] dxx, dyy, dzz, dxy, dxz, dyz, dxw, dyw, dzw;
  logic signed [EW-1:0] e_d [NUM_ELEM];
  logic signed [EW-1:0] s6_e_q [NUM_ELEM];
  logic                 s6_vld_q;

  assign dxx = EW'(s5_xx_q) <<< 1;
  assign dyy = EW'(s5_yy_q) <<< 1;
  assign dzz = EW'(s5_zz_q) <<< 1;
  assign dxy = EW'(s5_xy_q) <<< 1;
  assign dxz = EW'(s5_xz_q) <<< 1;
  assign dyz = EW'(s5_yz_q) <<< 1;
  assign dxw = EW'(s5_xw_q) <<< 1;
  assign dyw = EW'(s5_yw_q) <<< 1;
  assign dzw = EW'(s5_zw_q) <<< 1;

  // rounding half folded in here
  assign e_d[0] = ONE2 - dyy - dzz + HALF;
  assign e_d[1] = dxy - dzw + HALF;
  assign e_d[2] = dxz + dyw + HALF;
  assign e_d[3] = dxy + dzw + HALF;
  assign e_d[4] = ONE2 - dxx - dzz + HALF;
  assign e_d[5] = dyz - dxw + HALF;
  assign e_d[6] = dxz - dyw + HALF;
  assign e_d[7] = dyz + dxw + HALF;
  assign e_d[8] = ONE2 - dxx - dyy + HALF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_ELEM; i++) begin
      s6_e_q[i] <= e_d[i];
    end
  end

  // ---------------------------------------------------------------- round, saturate
  logic signed [EW-1:0]     sh_d  [NUM_ELEM];
  logic signed [DATA_W-1:0] out_d [NUM_ELEM];
  logic signed [DATA_W-1:0] out_q [NUM_ELEM];
  logic                     done_q;

  always_comb begin
    for (int i = 0; i < NUM_ELEM; i++) begin
      sh_d[i] = s6_e_q[i] >>> FRAC_BITS;   // floor
      if (sh_d[i] > SAT_HI) begin
        out_d[i] = SAT_HI[DATA_W-1:0];
      end else if (sh_d[i] < SAT_LO) begin
        out_d[i] = SAT_LO[DATA_W-1:0];
      end else begin
        out_d[i] = sh_d[i][DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_ELEM; i++) begin
      out_q[i] <= out_d[i];
    end
  end

  assign done_o = done_q;
  assign m00_o  = out_q[0];
  assign m01_o  = out_q[1];
  assign m02_o  = out_q[2];
  assign m10_o  = out_q[3];
  assign m11_o  = out_q[4];
  assign m12_o  = out_q[5];
  assign m20_o  = out_q[6];
  assign m21_o  = out_q[7];
  assign m22_o  = out_q[8];

  // ---------------------------------------------------------------- assertions
  `ASSERT_IMPLIES(a_result_latency, clk_i, rst_ni, done_o, $past(in_acc, LAT), "result without request")
  `ASSERT_IMPLIES(a_derived_w_range, clk_i, rst_ni, s4_vld_q && !s4_side_q.sel, (s4_w_q >= 0) && (s4_w_q <= W_ONE), "derived w out of range")
  `ASSERT_IMPLIES(a_diag_bound, clk_i, rst_ni, done_o, (m00_o <= DIAG_HI) && (m11_o <= DIAG_HI) && (m22_o <= DIAG_HI), "diagonal above one")

endmodule

/* sv/qrm_isqrt.sv */
// ----------------------------------------------------------------------------
// qrm_isqrt
// Pipelined integer square root, one result bit per stage, rounded to nearest.
// ----------------------------------------------------------------------------
module qrm_isqrt import qrm_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  qrm_side_t                side_i,
  input  logic [2*FRAC_BITS+1:0]   rad_i,
  output logic                     valid_o,
  output qrm_side_t                side_o,
  output logic [FRAC_BITS:0]       root_o
);

  localparam int unsigned N  = FRAC_BITS + 1;
  localparam int unsigned RB = 2 * N;

  logic            vld_q  [N];
  qrm_side_t       side_q [N];
  logic [RB-1:0]   rad_q  [N];
  logic [N+1:0]    rem_q  [N];
  logic [N-1:0]    root_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic            vin;
    qrm_side_t       sin;
    logic [RB-1:0]   rin;
    logic [N+1:0]    remin;
    logic [N-1:0]    rootin;
    logic [N+1:0]    rem_sh;
    logic [N+1:0]    trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign vin    = valid_i;
      assign sin    = side_i;
      assign rin    = rad_i;
      assign remin  = '0;
      assign rootin = '0;
    end else begin : g_next
      assign vin    = vld_q[k-1];
      assign sin    = side_q[k-1];
      assign rin    = rad_q[k-1];
      assign remin  = rem_q[k-1];
      assign rootin = root_q[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {remin[N-1:0], rin[RB-1 -: 2]};
    assign trial  = {rootin, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= sin;
      rad_q[k]  <= rin << 2;
      rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
      root_q[k] <= {rootin[N-2:0], ge};
    end
  end

  // remainder is r - root^2; round up when it exceeds root
  logic            out_vld_q;
  qrm_side_t       out_side_q;
  logic [N-1:0]    out_root_q;
  logic [N-1:0]    out_root_d;

  assign out_root_d = (rem_q[N-1] > {2'b00, root_q[N-1]}) ? (root_q[N-1] + 1'b1)
                                                        : root_q[N-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_side_q <= side_q[N-1];
    out_root_q <= out_root_d;
  end

  assign valid_o = out_vld_q;
  assign side_o  = out_side_q;
  assign root_o  = out_root_q;

endmodule

/* tb/tb_quaternion_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// tb_quaternion_to_rotation_matrix
// Drives quaternion requests in bursts with random gaps and predicts each
// 3x3 matrix in Q2.14, with w supplied or derived by square root. Results
// are compared element by element, in order, and the scalar_supplied
// register is written and read back over APB between phases.
// ----------------------------------------------------------------------------
module tb_quaternion_to_rotation_matrix;
  import qrm_pkg::*;

  localparam int unsigned FRAC      = FRAC_BITS_DEF;
  localparam int          DRAIN_CYC = 2 * (FRAC + 10);
  localparam longint      CYCLE_CAP = 200000;

  localparam logic [REG_ADDR_W-1:0] ADDR_SCALAR_SUPPLIED = {REG_SCALAR_SUPPLIED, 2'b00};
  localparam logic [REG_ADDR_W-1:0] ADDR_UNMAPPED        = 3'd4;

  localparam logic signed [DATA_W-1:0] Q_ONE  = 16'sd16384;
  localparam logic signed [DATA_W-1:0] Q_HALF = 16'sd8192;
  localparam logic signed [DATA_W-1:0] Q_MAX  = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] Q_MIN  = 16'sh8000;

  typedef logic [NUM_ELEM-1:0][DATA_W-1:0] matrix_t;

  class matrix_checker;
    bit      scalar_supplied = 1'b1;
    matrix_t expected_matrices[$];
    int      errors;
    int      results_seen;

    task report(input string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    // rounded to nearest; v - s*s > s means the root lies above s + 1/2
    function longint unsigned root_nearest(input longint unsigned v);
      longint unsigned s;
      longint unsigned trial;
      s = 0;
      for (int k = 31; k >= 0; k--) begin
        trial = s | (longint'(1) << k);
        if (trial * trial <= v) s = trial;
      end
      if (v - s * s > s) s++;
      return s;
    endfunction

    function logic [DATA_W-1:0] round_sat(input longint v);
      longint t;
      t = (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
      if (t > OUT_MAX) t = OUT_MAX;
      if (t < OUT_MIN) t = OUT_MIN;
      return t[DATA_W-1:0];
    endfunction

    function matrix_t predict_matrix(input logic signed [DATA_W-1:0] qx, qy, qz, qw);
      longint  x, y, z, w, one2, resid;
      longint  xx, yy, zz, xy, xz, yz, xw, yw, zw;
      matrix_t m;
      x = qx;
      y = qy;
      z = qz;
      one2 = longint'(1) << (2 * FRAC);
      if (scalar_supplied) begin
        w = qw;
      end else begin
        resid = one2 - x * x - y * y - z * z;
        w = (resid > 0) ? longint'(root_nearest(resid)) : 0;
      end
      xx = 2 * x * x; yy = 2 * y * y; zz = 2 * z * z;
      xy = 2 * x * y; xz = 2 * x * z; yz = 2 * y * z;
      xw = 2 * x * w; yw = 2 * y * w; zw = 2 * z * w;
      m[0] = round_sat(one2 - yy - zz);
      m[1] = round_sat(xy - zw);
      m[2] = round_sat(xz + yw);
      m[3] = round_sat(xy + zw);
      m[4] = round_sat(one2 - xx - zz);
      m[5] = round_sat(yz - xw);
      m[6] = round_sat(xz - yw);
      m[7] = round_sat(yz + xw);
      m[8] = round_sat(one2 - xx - yy);
      return m;
    endfunction

    function void note_request(input logic signed [DATA_W-1:0] qx, qy, qz, qw);
      expected_matrices.push_back(predict_matrix(qx, qy, qz, qw));
    endfunction

    task check_result(input matrix_t got);
      matrix_t want;
      string   names[NUM_ELEM];
      names = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
      if (expected_matrices.size() == 0) begin
        report($sformatf("result #%0d with no request outstanding", results_seen));
      end else begin
        want = expected_matrices.pop_front();
        for (int k = 0; k < NUM_ELEM; k++) begin
          if (got[k] !== want[k])
            report($sformatf("result #%0d %s: got %0d expected %0d", results_seen, names[k],
                             $signed(got[k]), $signed(want[k])));
        end
      end
      results_seen++;
    endtask

    function int pending();
      return expected_matrices.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic signed [DATA_W-1:0] qx_i, qy_i, qz_i, qw_i;
  logic                     done_o;
  logic signed [DATA_W-1:0] m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o;
  logic                     psel, penable, pwrite;
  logic [REG_ADDR_W-1:0]    paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  matrix_checker sb;
  longint        cycles;

  quaternion_to_rotation_matrix dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .qx_i   (qx_i),
    .qy_i   (qy_i),
    .qz_i   (qz_i),
    .qw_i   (qw_i),
    .done_o (done_o),
    .m00_o  (m00_o),
    .m01_o  (m01_o),
    .m02_o  (m02_o),
    .m10_o  (m10_o),
    .m11_o  (m11_o),
    .m12_o  (m12_o),
    .m20_o  (m20_o),
    .m21_o  (m21_o),
    .m22_o  (m22_o),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("tb_quaternion_to_rotation_matrix: FAIL");
      $finish;
    end
  end

  // request acceptance and result capture, sampled before this edge's updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_request(qx_i, qy_i, qz_i, qw_i);
      if (done_o)
        sb.check_result({m22_o, m21_o, m20_o, m12_o, m11_o, m10_o, m02_o, m01_o, m00_o});
    end
  end

  // called at a clock edge; returns at the edge that accepts the request
  task automatic send(input logic signed [DATA_W-1:0] x, y, z, w);
    start <= 1'b1;
    qx_i  <= x;
    qy_i  <= y;
    qz_i  <= z;
    qw_i  <= w;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [REG_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_SCALAR_SUPPLIED) sb.scalar_supplied = data[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_readback();
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_SCALAR_SUPPLIED;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (got !== {31'b0, sb.scalar_supplied})
      sb.report($sformatf("scalar_supplied read %0h expected %0h", got, sb.scalar_supplied));
  endtask

  task automatic configure(input logic [REG_ADDR_W-1:0] addr, input logic [31:0] data);
    drain();
    reg_write(addr, data);
    check_readback();
  endtask

  function automatic logic signed [DATA_W-1:0] pick_comp(input int kind, input int lim);
    logic signed [DATA_W-1:0] edges[5];
    edges = '{-Q_ONE, -16'sd1, 16'sd0, 16'sd1, Q_ONE};
    if (kind <= 5) return $signed(DATA_W'($urandom_range(0, 2 * lim) - lim));
    if (kind <= 7) return edges[$urandom_range(0, 4)];
    return $signed(DATA_W'($urandom));
  endfunction

  task automatic random_phase(input int n_items);
    int kind, lim, burst_left, pause_at;
    int lims[4];
    lims = '{16384, 9459, 4096, 512};
    burst_left = $urandom_range(1, 20);
    pause_at = $urandom_range(0, n_items - 1);
    for (int i = 0; i < n_items; i++) begin
      if (i == pause_at) drain();
      if (burst_left == 0) begin
        idle($urandom_range(1, 6));
        burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 20);
      end
      kind = $urandom_range(0, 9);
      lim  = lims[$urandom_range(0, 3)];
      send(pick_comp(kind, lim), pick_comp(kind, lim), pick_comp(kind, lim),
           pick_comp(kind, lim));
      burst_left--;
    end
  endtask

  initial begin
    bit settings[6];
    settings = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    sb = new();
    cycles  <= 0;
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    qx_i    <= '0;
    qy_i    <= '0;
    qz_i    <= '0;
    qw_i    <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // w supplied (reset setting): axes, half turns, saturation, raw extremes
    check_readback();
    send(16'sd0, 16'sd0, 16'sd0, Q_ONE);
    send(Q_ONE, 16'sd0, 16'sd0, 16'sd0);
    send(16'sd0, Q_ONE, 16'sd0, 16'sd0);
    send(16'sd0, 16'sd0, Q_ONE, 16'sd0);
    send(-Q_ONE, 16'sd0, 16'sd0, 16'sd0);
    send(16'sd0, 16'sd0, 16'sd0, -Q_ONE);
    send(Q_HALF, Q_HALF, Q_HALF, Q_HALF);
    send(-Q_HALF, Q_HALF, -Q_HALF, Q_HALF);
    send(Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    send(-Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE);
    send(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    send(16'sd1, -16'sd1, 16'sd1, -16'sd1);

    // only bit 0 is kept; the unmapped address has no effect
    configure(ADDR_SCALAR_SUPPLIED, 32'hffff_fffe);
    configure(ADDR_UNMAPPED, 32'h0000_0001);

    // derived w: zero vector, unit norm (r = 0), r < 0, raw extremes
    send(16'sd0, 16'sd0, 16'sd0, Q_MAX);
    send(Q_ONE, 16'sd0, 16'sd0, 16'sd0);
    send(Q_HALF, Q_HALF, Q_HALF, Q_MAX);
    send(Q_ONE, Q_ONE, 16'sd0, 16'sd0);
    send(Q_MIN, Q_MIN, Q_MIN, 16'sd0);
    send(16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send(16'sd11585, 16'sd0, -16'sd11585, Q_MIN);
    send(Q_MAX, 16'sd0, 16'sd0, 16'sd0);

    foreach (settings[p]) begin
      configure(ADDR_SCALAR_SUPPLIED, {$urandom} & ~32'h1 | 32'(settings[p]));
      random_phase(92);
    end

    drain();
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("tb_quaternion_to_rotation_matrix: PASS");
    end else begin
      $display("tb_quaternion_to_rotation_matrix: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/qrm_pkg.sv
sv/qrm_isqrt.sv
sv/quaternion_to_rotation_matrix.sv
tb/tb_quaternion_to_rotation_matrix.sv
